>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/bsc_pkg.sv
// Shared widths, register indexes and stage payload types of the
// barometric compensation pipeline. No dependencies.
package bsc_pkg;

  localparam int RAW_W    = 24;
  localparam int CAL_W    = 16;
  localparam int TEMP_W   = 19;
  localparam int PRES_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int WIDE_W   = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } cal_t;

  // First-order results plus what the low-temperature terms need.
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp1;
    logic signed [17:0]       q;
    logic signed [TEMP_W-1:0] vl;
    logic [16:0]              t2;
    logic                     low;
    logic                     very_low;
    logic signed [WIDE_W-1:0] off1;
    logic signed [WIDE_W-1:0] sens1;
    logic [RAW_W-1:0]         d1;
  } front_t;

  // Corrected temperature, offset and sensitivity.
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic signed [WIDE_W-1:0] off;
    logic signed [WIDE_W-1:0] sens;
    logic [RAW_W-1:0]         d1;
  } corr_t;

endpackage

>>> hdl/bsc_raw_if.sv
// Input channel: one raw temperature/pressure reading pair per item.
// Depends on bsc_pkg for field widths.
interface bsc_raw_if;
  import bsc_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_temperature;
  logic [RAW_W-1:0] raw_pressure;

  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

>>> hdl/bsc_comp_if.sv
// Output channel: compensated temperature and pressure per item.
// Depends on bsc_pkg for field widths.
interface bsc_comp_if;
  import bsc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_centi;
  logic signed [PRES_W-1:0] pressure_centi;

  modport source (output valid, temperature_centi, pressure_centi, input ready);
  modport sink   (input valid, temperature_centi, pressure_centi, output ready);
endinterface

>>> hdl/bsc_front.sv
// Stages 1-3: dT, the four dT products, first-order TEMP/OFF/SENS.
// Depends on bsc_pkg.
module bsc_front (
  input  logic             clk,
  input  logic             rst,
  input  bsc_pkg::cal_t    cal,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [23:0]      in_d2,
  input  logic [23:0]      in_d1,
  output logic             out_valid,
  input  logic             out_ready,
  output bsc_pkg::front_t  out
);
  import bsc_pkg::*;

  logic [2:0] v;
  logic [2:0] adv;

  // stage 1
  logic signed [24:0] dt1;
  logic [RAW_W-1:0]   d1_1;
  // stage 2
  logic signed [41:0] p6, p4, p3;
  logic signed [49:0] pdd;
  logic [RAW_W-1:0]   d1_2;
  // stage 3 next values
  logic signed [41:0] p6b, p4b, p3b;
  logic signed [17:0] q_next;
  front_t             out_next;

  assign adv[2]   = !v[2] || out_ready;
  assign adv[1]   = !v[1] || adv[2];
  assign adv[0]   = !v[0] || adv[1];
  assign in_ready = adv[0];
  assign out_valid = v[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      if (adv[1]) v[1] <= v[0];
      if (adv[2]) v[2] <= v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dt1  <= $signed({1'b0, in_d2}) - $signed({1'b0, cal.c5, 8'h00});
      d1_1 <= in_d1;
    end
    if (adv[1]) begin
      p6   <= dt1 * $signed({1'b0, cal.c6});
      p4   <= dt1 * $signed({1'b0, cal.c4});
      p3   <= dt1 * $signed({1'b0, cal.c3});
      pdd  <= dt1 * dt1;
      d1_2 <= d1_1;
    end
    if (adv[2]) begin
      out <= out_next;
    end
  end

  // Bias negative values so the arithmetic shift truncates toward zero.
  always_comb begin
    p6b = p6 + (p6[41] ? 42'sd8388607 : 42'sd0);
    p4b = p4 + (p4[41] ? 42'sd127 : 42'sd0);
    p3b = p3 + (p3[41] ? 42'sd255 : 42'sd0);
    q_next = p6b[40:23];

    out_next.q        = q_next;
    out_next.temp1    = 19'sd2000 + TEMP_W'(q_next);
    out_next.vl       = TEMP_W'(q_next) + 19'sd3500;
    out_next.low      = q_next[17];
    out_next.very_low = (q_next < -18'sd3500);
    out_next.t2       = pdd[47:31];
    out_next.off1     = $signed({8'h00, cal.c2, 16'h0000}) + WIDE_W'($signed(p4b[41:7]));
    out_next.sens1    = $signed({9'h000, cal.c1, 15'h0000}) + WIDE_W'($signed(p3b[41:8]));
    out_next.d1       = d1_2;
  end

endmodule

>>> hdl/bsc_corr.sv
// Stages 4-6: squares, second-order terms, corrected TEMP/OFF/SENS.
// Depends on bsc_pkg.
module bsc_corr (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bsc_pkg::front_t  in,
  output logic             out_valid,
  input  logic             out_ready,
  output bsc_pkg::corr_t   out
);
  import bsc_pkg::*;

  logic [2:0] v;
  logic [2:0] adv;

  // stage 4
  logic signed [35:0] sq_full;
  logic signed [37:0] sq2_full;
  logic [34:0]        sq, sq2;
  front_t             f4;
  // stage 5
  logic [38:0]        sq5, sq2x7, sq2x11;
  logic [38:0]        off2_next, sens2_next;
  logic [38:0]        off2, sens2;
  front_t             f5;
  // stage 6
  logic signed [19:0] temp_wide;
  corr_t              out_next;

  assign adv[2]    = !v[2] || out_ready;
  assign adv[1]    = !v[1] || adv[2];
  assign adv[0]    = !v[0] || adv[1];
  assign in_ready  = adv[0];
  assign out_valid = v[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      if (adv[1]) v[1] <= v[0];
      if (adv[2]) v[2] <= v[1];
    end
  end

  assign sq_full  = in.q * in.q;
  assign sq2_full = in.vl * in.vl;

  always_comb begin
    sq5    = (39'(sq) << 2) + 39'(sq);
    sq2x7  = (39'(sq2) << 3) - 39'(sq2);
    sq2x11 = (39'(sq2) << 3) + (39'(sq2) << 1) + 39'(sq2);
    off2_next  = '0;
    sens2_next = '0;
    if (f4.low) begin
      off2_next  = (sq5 >> 1) + (f4.very_low ? sq2x7 : 39'd0);
      sens2_next = (sq5 >> 2) + (f4.very_low ? (sq2x11 >> 1) : 39'd0);
    end
  end

  always_comb begin
    temp_wide = 20'(f5.temp1) - (f5.low ? $signed({3'b000, f5.t2}) : 20'sd0);
    out_next.temp = temp_wide[18:0];
    out_next.off  = f5.off1 - $signed({1'b0, off2});
    out_next.sens = f5.sens1 - $signed({1'b0, sens2});
    out_next.d1   = f5.d1;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sq  <= sq_full[34:0];
      sq2 <= sq2_full[34:0];
      f4  <= in;
    end
    if (adv[1]) begin
      off2  <= off2_next;
      sens2 <= sens2_next;
      f5    <= f4;
    end
    if (adv[2]) begin
      out <= out_next;
    end
  end

endmodule

>>> hdl/bsc_press.sv
// Stages 7-10: D1*SENS from two partial products, then the pressure.
// Depends on bsc_pkg.
module bsc_press (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bsc_pkg::corr_t                 in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [bsc_pkg::TEMP_W-1:0] temp,
  output logic signed [bsc_pkg::PRES_W-1:0] pres
);
  import bsc_pkg::*;

  logic [3:0] v;
  logic [3:0] adv;

  // stage 7
  logic [43:0]              pp_lo;
  logic signed [44:0]       pp_hi;
  logic signed [WIDE_W-1:0] off7;
  logic signed [TEMP_W-1:0] temp7;
  // stage 8
  logic signed [63:0]       prod, prod_next;
  logic signed [WIDE_W-1:0] off8;
  logic signed [TEMP_W-1:0] temp8;
  // stage 9
  logic signed [63:0]       prodb;
  logic signed [43:0]       a, a_next;
  logic signed [TEMP_W-1:0] temp9;
  // stage 10
  logic signed [43:0]       ab;

  assign adv[3]    = !v[3] || out_ready;
  assign adv[2]    = !v[2] || adv[3];
  assign adv[1]    = !v[1] || adv[2];
  assign adv[0]    = !v[0] || adv[1];
  assign in_ready  = adv[0];
  assign out_valid = v[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      if (adv[1]) v[1] <= v[0];
      if (adv[2]) v[2] <= v[1];
      if (adv[3]) v[3] <= v[2];
    end
  end

  // Recombine: hi part weighs 2^20; the product fits 64 bits.
  assign prod_next = $signed({pp_hi[43:0], 20'h00000}) + $signed({20'h00000, pp_lo});

  always_comb begin
    prodb  = prod + (prod[63] ? 64'sd2097151 : 64'sd0);
    a_next = 44'($signed(prodb[63:21])) - 44'(off8);
    ab     = a + (a[43] ? 44'sd32767 : 44'sd0);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pp_lo <= in.d1 * in.sens[19:0];
      pp_hi <= $signed({1'b0, in.d1}) * $signed(in.sens[39:20]);
      off7  <= in.off;
      temp7 <= in.temp;
    end
    if (adv[1]) begin
      prod  <= prod_next;
      off8  <= off7;
      temp8 <= temp7;
    end
    if (adv[2]) begin
      a     <= a_next;
      temp9 <= temp8;
    end
    if (adv[3]) begin
      // |a| < 2^43, so the quotient stays well inside 32 bits without a clamp.
      pres <= PRES_W'($signed(ab[43:15]));
      temp <= temp9;
    end
  end

endmodule

>>> hdl/baro_sensor_compensation_top.sv
// Top level of the barometric sensor compensation pipeline.
// Depends on bsc_pkg, bsc_raw_if, bsc_comp_if, bsc_front, bsc_corr, bsc_press, assert_macros.svh.
//
//   port     | dir  | carries
//   ---------+------+----------------------------------------------
//   raw      | in   | item: raw_temperature (D2), raw_pressure (D1)
//   comp     | out  | item: temperature_centi, pressure_centi
//   cfg_*    | in   | write of calibration word C1..C6 by index
//
// Ten register stages; an item enters every cycle unless a stall on comp
// holds the pipeline full. The depth is set by the dT products, the two
// squares and the D1*SENS product split into two partial products.
// Reset clears the stage valid bits and the six calibration words.
// A stall on comp holds each full stage; empty stages still fill.
`include "assert_macros.svh"

module baro_sensor_compensation_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  bsc_raw_if.sink     raw,
  bsc_comp_if.source  comp
);
  import bsc_pkg::*;

  cal_t   cal;
  front_t front_out;
  corr_t  corr_out;
  logic   front_valid, front_ready;
  logic   corr_valid, corr_ready;

  // Calibration words; indexes beyond C6 drop the write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_C1:  cal.c1 <= cfg_data;
        REG_C2:  cal.c2 <= cfg_data;
        REG_C3:  cal.c3 <= cfg_data;
        REG_C4:  cal.c4 <= cfg_data;
        REG_C5:  cal.c5 <= cfg_data;
        REG_C6:  cal.c6 <= cfg_data;
        default: ;
      endcase
    end
  end

  // dT, its products, first-order terms.
  bsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cal       (cal),
    .in_valid  (raw.valid),
    .in_ready  (raw.ready),
    .in_d2     (raw.raw_temperature),
    .in_d1     (raw.raw_pressure),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out       (front_out)
  );

  // Second-order correction below 20.00 C, extra term below -15.00 C.
  bsc_corr u_corr (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in        (front_out),
    .out_valid (corr_valid),
    .out_ready (corr_ready),
    .out       (corr_out)
  );

  // Pressure from D1*SENS and OFF; last stage is the output register.
  bsc_press u_press (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (corr_valid),
    .in_ready  (corr_ready),
    .in        (corr_out),
    .out_valid (comp.valid),
    .out_ready (comp.ready),
    .temp      (comp.temperature_centi),
    .pres      (comp.pressure_centi)
  );

  // Input held off only when every stage is full, so a result must wait.
  `BSC_ASSERT_IMP(a_full_when_blocked, !raw.ready, comp.valid, "input blocked with empty output")
  // A write to C1 lands on the next cycle.
  `BSC_ASSERT_NXT(a_c1_write, cfg_wr_en && cfg_index == REG_C1, cal.c1 == $past(cfg_data), "C1 write lost")
  // Writes beyond the register list change nothing.
  `BSC_ASSERT_NXT(a_bad_index, cfg_wr_en && cfg_index > REG_C6, $stable(cal), "write beyond C6 took effect")

endmodule
